### rtl/sru_pkg.sv
package sru_pkg;

    localparam int DATA_W        = 32;
    localparam int ACC_W         = 64;
    localparam int MAX_GROUP_LEN = 4096;
    localparam int FRAC_BITS     = 16;
    localparam int CNT_W         = $clog2(MAX_GROUP_LEN + 1);
    localparam int POS_W         = $clog2(MAX_GROUP_LEN);
    localparam int MODE_W        = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CNT_W     = $clog2(ACC_W);

    localparam logic [MODE_W-1:0] MODE_SUM    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PROD   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MAX    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MIN    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ARGMAX = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ARGMIN = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ANY    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ALL    = 4'd8;

    localparam logic signed [DATA_W-1:0] ONE_FIXED = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     saturated;
    } t_out;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [ACC_W-1:0] acc;
        logic [CNT_W-1:0]        count;
        logic [POS_W-1:0]        best;
        logic                    ovf;
    } t_job;

    function automatic logic f_fits32(input logic signed [ACC_W-1:0] x);
        return (x[ACC_W-1:DATA_W-1] == '0) || (x[ACC_W-1:DATA_W-1] == '1);
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (f_fits32(x)) begin
            r = x[DATA_W-1:0];
        end else if (x[ACC_W-1]) begin
            r = DATA_MIN;
        end else begin
            r = DATA_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sext(input logic signed [DATA_W-1:0] x);
        return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic logic [MODE_W-1:0] f_mode(input logic [MODE_W-1:0] m);
        return (m > MODE_ALL) ? MODE_SUM : m;
    endfunction

endpackage

### rtl/sru_front.sv
module sru_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  sru_pkg::t_in                      i_data,
    output logic                              o_stall,
    input  logic [sru_pkg::MODE_W-1:0]        i_mode,
    input  logic                              i_queue_ready,
    output logic                              o_push,
    output sru_pkg::t_job                     o_job
);

    logic signed [sru_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [sru_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [sru_pkg::POS_W-1:0]         r_best, n_best;
    logic                              r_ovf, n_ovf;

    logic                              w_accept;
    logic [sru_pkg::MODE_W-1:0]        w_mode;
    logic signed [sru_pkg::ACC_W-1:0]  w_v;
    logic                              w_nz;
    logic signed [sru_pkg::DATA_W-1:0] w_a_sat;
    logic signed [sru_pkg::ACC_W-1:0]  w_prod;
    logic signed [sru_pkg::ACC_W-1:0]  w_prod_sh;

    assign o_stall   = !i_queue_ready;
    assign w_accept  = i_valid && !o_stall;
    assign w_mode    = sru_pkg::f_mode(i_mode);
    assign w_v       = sru_pkg::f_sext(i_data.value);
    assign w_nz      = (i_data.value != '0);
    assign w_a_sat   = sru_pkg::f_sat32(r_acc);
    assign w_prod    = w_a_sat * i_data.value;
    assign w_prod_sh = w_prod >>> sru_pkg::FRAC_BITS;

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_best = r_best;
        n_ovf  = r_ovf;
        if (r_cnt >= sru_pkg::CNT_W'(sru_pkg::MAX_GROUP_LEN)) begin
            n_ovf = 1'b1;
        end else if (r_cnt == '0) begin
            if (w_mode == sru_pkg::MODE_ANY || w_mode == sru_pkg::MODE_ALL) begin
                n_acc = {{(sru_pkg::ACC_W-1){1'b0}}, w_nz};
            end else begin
                n_acc = w_v;
            end
            n_best = '0;
            n_cnt  = sru_pkg::CNT_W'(1);
        end else begin
            case (w_mode) inside
                sru_pkg::MODE_PROD: begin
                    if (!sru_pkg::f_fits32(r_acc) || !sru_pkg::f_fits32(w_prod_sh)) begin
                        n_ovf = 1'b1;
                    end
                    n_acc = sru_pkg::f_sext(sru_pkg::f_sat32(w_prod_sh));
                end
                sru_pkg::MODE_MAX, sru_pkg::MODE_ARGMAX: begin
                    if (w_v > r_acc) begin
                        n_acc = w_v;
                        if (w_mode == sru_pkg::MODE_ARGMAX) begin
                            n_best = r_cnt[sru_pkg::POS_W-1:0];
                        end
                    end
                end
                sru_pkg::MODE_MIN, sru_pkg::MODE_ARGMIN: begin
                    if (w_v < r_acc) begin
                        n_acc = w_v;
                        if (w_mode == sru_pkg::MODE_ARGMIN) begin
                            n_best = r_cnt[sru_pkg::POS_W-1:0];
                        end
                    end
                end
                sru_pkg::MODE_ANY: begin
                    n_acc = {{(sru_pkg::ACC_W-1){1'b0}}, (r_acc != '0) || w_nz};
                end
                sru_pkg::MODE_ALL: begin
                    n_acc = {{(sru_pkg::ACC_W-1){1'b0}}, (r_acc != '0) && w_nz};
                end
                default: begin
                    n_acc = r_acc + w_v;
                end
            endcase
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign o_push     = w_accept && i_data.last;
    assign o_job.mode  = w_mode;
    assign o_job.acc   = n_acc;
    assign o_job.count = n_cnt;
    assign o_job.best  = n_best;
    assign o_job.ovf   = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_best <= '0;
            r_ovf  <= 1'b0;
        end else if (w_accept) begin
            if (i_data.last) begin
                r_acc  <= '0;
                r_cnt  <= '0;
                r_best <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_acc  <= n_acc;
                r_cnt  <= n_cnt;
                r_best <= n_best;
                r_ovf  <= n_ovf;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sru_pkg::CNT_W'(sru_pkg::MAX_GROUP_LEN))
        else $error("element count above group limit");

    a_group_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.last) |=> (r_cnt == '0 && !r_ovf && r_acc == '0))
        else $error("group state not cleared after last element");

endmodule

### rtl/sru_queue.sv
module sru_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sru_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output sru_pkg::t_job o_job,
    input  logic          i_pop
);

    sru_pkg::t_job              r_mem [sru_pkg::QUEUE_DEPTH];
    logic [sru_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [sru_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [sru_pkg::QCNT_W-1:0] r_count;

    assign o_ready = (r_count < sru_pkg::QCNT_W'(sru_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < sru_pkg::QCNT_W'(sru_pkg::QUEUE_DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

### rtl/sru_back.sv
module sru_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  sru_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    output sru_pkg::t_out o_data,
    input  logic          i_stall
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_back_state;

    t_back_state                       r_state;
    logic                              r_out_valid;
    sru_pkg::t_out                     r_out;
    logic [sru_pkg::ACC_W-1:0]         r_quo;
    logic [sru_pkg::CNT_W-1:0]         r_rem;
    logic [sru_pkg::CNT_W-1:0]         r_den;
    logic                              r_neg;
    logic                              r_div_ovf;
    logic [sru_pkg::DIV_CNT_W-1:0]     r_div_cnt;

    logic                              w_out_free;
    logic                              w_is_mean;
    logic                              w_load_fin;
    logic                              w_load_div;
    logic                              w_div_step;
    logic                              w_load_mean;
    logic [sru_pkg::ACC_W-1:0]         w_abs;
    logic [sru_pkg::CNT_W:0]           w_rem_sh;
    logic                              w_ge;
    logic signed [sru_pkg::ACC_W-1:0]  w_q_signed;
    logic signed [sru_pkg::DATA_W-1:0] w_mean_result;
    logic signed [sru_pkg::ACC_W-1:0]  w_pos_scaled;
    logic signed [sru_pkg::DATA_W-1:0] w_fin_result;
    logic                              w_fin_sat;

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_is_mean   = (i_job.mode == sru_pkg::MODE_MEAN);
    assign o_pop       = (r_state == ST_IDLE) && i_job_valid && (w_is_mean || w_out_free);
    assign w_load_fin  = o_pop && !w_is_mean;
    assign w_load_div  = o_pop && w_is_mean;
    assign w_div_step  = (r_state == ST_DIV);
    assign w_load_mean = (r_state == ST_DONE) && w_out_free;

    assign w_abs    = i_job.acc[sru_pkg::ACC_W-1] ? (-i_job.acc) : i_job.acc;
    assign w_rem_sh = {r_rem, r_quo[sru_pkg::ACC_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    assign w_q_signed    = r_neg ? (-r_quo) : r_quo;
    assign w_mean_result = sru_pkg::f_sat32(w_q_signed);
    assign w_pos_scaled  = {{(sru_pkg::ACC_W-sru_pkg::POS_W){1'b0}}, i_job.best}
                           << sru_pkg::FRAC_BITS;

    always_comb begin
        w_fin_result = sru_pkg::f_sat32(i_job.acc);
        w_fin_sat    = i_job.ovf;
        case (i_job.mode) inside
            sru_pkg::MODE_MAX, sru_pkg::MODE_MIN: begin
                w_fin_result = sru_pkg::f_sat32(i_job.acc);
            end
            sru_pkg::MODE_ARGMAX, sru_pkg::MODE_ARGMIN: begin
                w_fin_result = sru_pkg::f_sat32(w_pos_scaled);
            end
            sru_pkg::MODE_ANY, sru_pkg::MODE_ALL: begin
                w_fin_result = (i_job.acc != '0) ? sru_pkg::ONE_FIXED : '0;
            end
            default: begin
                w_fin_sat = i_job.ovf || !sru_pkg::f_fits32(i_job.acc);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (w_load_fin || w_load_mean) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_load_div) begin
                        r_state   <= ST_DIV;
                        r_div_cnt <= sru_pkg::DIV_CNT_W'(sru_pkg::ACC_W - 1);
                    end
                end
                ST_DIV: begin
                    if (r_div_cnt == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_div_cnt <= r_div_cnt - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_fin) begin
            r_out.result    <= w_fin_result;
            r_out.saturated <= w_fin_sat;
        end else if (w_load_mean) begin
            r_out.result    <= w_mean_result;
            r_out.saturated <= r_div_ovf;
        end
        if (w_load_div) begin
            r_quo     <= w_abs;
            r_rem     <= '0;
            r_den     <= i_job.count;
            r_neg     <= i_job.acc[sru_pkg::ACC_W-1];
            r_div_ovf <= i_job.ovf;
        end else if (w_div_step) begin
            r_quo <= {r_quo[sru_pkg::ACC_W-2:0], w_ge};
            r_rem <= w_ge ? sru_pkg::CNT_W'(w_rem_sh - {1'b0, r_den})
                          : w_rem_sh[sru_pkg::CNT_W-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_den != '0))
        else $error("mean division by zero count");

endmodule

### rtl/stream_reduction_unit.sv
// Channel    Direction  Handshake                 Payload
// input      in         i_valid / o_stall         i_data   (value, last)
// result     out        o_valid / i_stall         o_data   (result, saturated)
// config     in         i_cfg_valid / o_cfg_ready i_cfg_data (reduce_mode)
//
// Elements are taken one per cycle; the input stalls only while two finished groups wait.
// A group result passes through the job queue and then the output register before it reaches o_data.
// Mean adds a 64-step radix-2 divider between the job queue and the output register.
// Synchronous active-low reset clears the mode to sum and the running group state.
// A stalled result holds in the output register while the next group keeps accumulating.
module stream_reduction_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  sru_pkg::t_in               i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output sru_pkg::t_out              o_data,
    input  logic                       i_stall,
    input  logic                       i_cfg_valid,
    input  logic [sru_pkg::MODE_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);

    logic [sru_pkg::MODE_W-1:0] r_mode;
    logic                       w_push;
    logic                       w_queue_ready;
    logic                       w_job_valid;
    logic                       w_pop;
    sru_pkg::t_job              w_job_in;
    sru_pkg::t_job              w_job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sru_pkg::MODE_SUM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    sru_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data        (i_data),
        .o_stall       (o_stall),
        .i_mode        (r_mode),
        .i_queue_ready (w_queue_ready),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    sru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_ready (w_queue_ready),
        .o_valid (w_job_valid),
        .o_job   (w_job_out),
        .i_pop   (w_pop)
    );

    sru_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule

### verif/stream_reduction_unit_test.sv
`timescale 1ns / 100ps

module stream_reduction_unit_test;
    import sru_pkg::*;

    localparam int                IDLE_LIMIT  = 2000;
    localparam int                CFG_SETTLE  = 80;
    localparam int                DRAIN_WAIT  = 100;
    localparam int                HOLD_CYCLES = 300;
    localparam int                RAND_ITEMS  = 1050;
    localparam logic [MODE_W-1:0] MODE_TOP    = 4'hF;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    t_in               i_data;
    logic              o_stall;
    logic              o_valid;
    t_out              o_data;
    logic              i_stall;
    logic              i_cfg_valid;
    logic [MODE_W-1:0] i_cfg_data;
    logic              o_cfg_ready;

    // reduction state
    longint            running_acc   = 0;
    int                element_total = 0;
    int                peak_index    = 0;
    bit                group_ovf     = 1'b0;
    logic [MODE_W-1:0] mode_reg      = MODE_SUM;

    t_out pending_results[$];
    int   error_count   = 0;
    int   idle_cycles   = 0;
    bit   send_idle     = 1'b1;
    bit   take_idle     = 1'b1;
    bit   hold_request  = 1'b0;

    stream_reduction_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint clamp32(input longint x, inout bit flag);
        if (x > longint'(DATA_MAX)) begin
            flag = 1'b1;
            return longint'(DATA_MAX);
        end
        if (x < longint'(DATA_MIN)) begin
            flag = 1'b1;
            return longint'(DATA_MIN);
        end
        return x;
    endfunction

    function automatic bit reduce_element(input t_in item, output t_out res);
        longint            v;
        longint            a;
        longint            r;
        logic [MODE_W-1:0] m;
        bit                nz;
        bit                flag;
        bit                spare;
        v     = longint'(item.value);
        m     = (mode_reg > MODE_ALL) ? MODE_SUM : mode_reg;
        nz    = (item.value != 0);
        res   = '0;
        spare = 1'b0;
        if (element_total >= MAX_GROUP_LEN) begin
            group_ovf = 1'b1;
        end else if (element_total == 0) begin
            running_acc   = (m == MODE_ANY || m == MODE_ALL) ? longint'(nz) : v;
            peak_index    = 0;
            element_total = 1;
        end else begin
            a = running_acc;
            case (m)
                MODE_PROD: begin
                    a = clamp32(a, group_ovf);
                    running_acc = clamp32((a * v) >>> FRAC_BITS, group_ovf);
                end
                MODE_MAX: if (v > a) running_acc = v;
                MODE_MIN: if (v < a) running_acc = v;
                MODE_ARGMAX: begin
                    if (v > a) begin
                        running_acc = v;
                        peak_index  = element_total;
                    end
                end
                MODE_ARGMIN: begin
                    if (v < a) begin
                        running_acc = v;
                        peak_index  = element_total;
                    end
                end
                MODE_ANY: running_acc = longint'(running_acc != 0 || nz);
                MODE_ALL: running_acc = longint'(running_acc != 0 && nz);
                default:  running_acc = running_acc + v;
            endcase
            element_total++;
        end
        if (!item.last) begin
            return 1'b0;
        end
        a    = running_acc;
        flag = group_ovf;
        case (m)
            MODE_MEAN:               r = clamp32(a / longint'(element_total), spare);
            MODE_MAX, MODE_MIN:      r = clamp32(a, spare);
            MODE_ARGMAX, MODE_ARGMIN: r = clamp32(longint'(peak_index) << FRAC_BITS, spare);
            MODE_ANY, MODE_ALL:      r = (a != 0) ? longint'(ONE_FIXED) : 0;
            default:                 r = clamp32(a, flag);
        endcase
        res.result    = r[DATA_W-1:0];
        res.saturated = flag;
        running_acc   = 0;
        element_total = 0;
        peak_index    = 0;
        group_ovf     = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = DATA_MAX;
            2:       v = DATA_MIN;
            3, 4:    v = int'($urandom_range(0, 8191)) - 4096;
            5, 6: begin
                v = ONE_FIXED + int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            7:       v = ($urandom_range(0, 1) == 1) ? 1 : -1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [MODE_W-1:0] random_mode();
        if ($urandom_range(0, 3) == 0) begin
            return MODE_W'($urandom_range(MODE_SUM, MODE_TOP));
        end
        return MODE_W'($urandom_range(MODE_SUM, MODE_ALL));
    endfunction

    task automatic send_element(input logic signed [DATA_W-1:0] value, input bit last);
        int   gap;
        t_in  item;
        t_out res;
        gap        = send_idle ? $urandom_range(0, 9) : 0;
        item.value = value;
        item.last  = last;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        if (reduce_element(item, res)) begin
            pending_results.push_back(res);
        end
    endtask

    task automatic send_group(input logic signed [DATA_W-1:0] vals[$]);
        foreach (vals[k]) begin
            send_element(vals[k], k == vals.size() - 1);
        end
    endtask

    // drain, then write the mode register
    task automatic write_mode(input logic [MODE_W-1:0] m);
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_reg = m;
    endtask

    task automatic test_reset_mode();
        send_group('{32'sd5, -32'sd9, DATA_MAX});
    endtask

    task automatic test_each_mode();
        write_mode(MODE_SUM);
        send_group('{DATA_MAX, DATA_MAX});
        write_mode(MODE_MEAN);
        send_group('{-32'sd3, -32'sd4});
        write_mode(MODE_PROD);
        send_group('{DATA_MAX, DATA_MAX});
        send_group('{-32'sd1, 32'sd1});
        write_mode(MODE_MAX);
        send_group('{DATA_MIN, 32'sd5, DATA_MAX});
        write_mode(MODE_MIN);
        send_group('{DATA_MAX, DATA_MIN});
        write_mode(MODE_ARGMAX);
        send_group('{32'sd7, 32'sd7, 32'sd3});
        write_mode(MODE_ARGMIN);
        send_group('{32'sd3, -32'sd1, -32'sd1});
        write_mode(MODE_ANY);
        send_group('{32'sd0, 32'sd0});
        write_mode(MODE_ALL);
        send_group('{32'sd1, 32'sd0, 32'sd1});
        write_mode(MODE_TOP);
        send_group('{DATA_MAX, 32'sd1});
    endtask

    task automatic test_mode_switch();
        write_mode(MODE_SUM);
        send_element(DATA_MAX, 1'b0);
        send_element(DATA_MAX, 1'b0);
        write_mode(MODE_PROD);
        send_element(ONE_FIXED, 1'b0);
        write_mode(MODE_ARGMAX);
        send_element(32'sd0, 1'b1);
    endtask

    task automatic test_group_limit();
        int peak;
        send_idle = 1'b0;
        take_idle = 1'b0;
        write_mode(MODE_MEAN);
        for (int k = 0; k < MAX_GROUP_LEN + 4; k++) begin
            send_element(rand_value(), k == MAX_GROUP_LEN + 3);
        end
        write_mode(MODE_ARGMAX);
        peak = $urandom_range(MAX_GROUP_LEN / 2, MAX_GROUP_LEN - 1);
        for (int k = 0; k < MAX_GROUP_LEN; k++) begin
            send_element((k == peak) ? DATA_MAX : int'($urandom_range(0, 65535)),
                         k == MAX_GROUP_LEN - 1);
        end
        send_idle = 1'b1;
        take_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        int len;
        write_mode(MODE_SUM);
        send_idle    = 1'b0;
        take_idle    = 1'b0;
        hold_request = 1'b1;
        for (int g = 0; g < 12; g++) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
                send_element(rand_value(), k == len - 1);
            end
        end
        send_idle = 1'b1;
        take_idle = 1'b1;
    endtask

    task automatic test_random();
        int items_sent;
        int groups;
        int len;
        int switch_at;
        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            send_idle = ($urandom_range(0, 3) != 0);
            take_idle = ($urandom_range(0, 3) != 0);
            write_mode(random_mode());
            groups = $urandom_range(1, 6);
            for (int g = 0; g < groups; g++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                switch_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : 0;
                for (int k = 0; k < len; k++) begin
                    if (k > 0 && k == switch_at) write_mode(random_mode());
                    send_element(rand_value(), k == len - 1);
                end
                items_sent += len;
            end
        end
        send_idle = 1'b1;
        take_idle = 1'b1;
    endtask

    // result side: stall per transaction, long hold on request
    initial begin
        int wait_cycles;
        i_stall <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            wait_cycles = take_idle ? $urandom_range(0, 9) : 0;
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid && !hold_request);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: result %0d saturated %0b",
                       o_data.result, o_data.saturated);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.result !== want.result) begin
                    $error("result: expected %0d, got %0d", want.result, o_data.result);
                    error_count++;
                end
                if (o_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b", want.saturated,
                           o_data.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_mode();
        test_each_mode();
        test_mode_switch();
        test_backpressure();
        test_group_limit();
        test_random();
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
rtl/sru_pkg.sv
rtl/sru_front.sv
rtl/sru_queue.sv
rtl/sru_back.sv
rtl/stream_reduction_unit.sv
verif/stream_reduction_unit_test.sv
